@@ hdl/fdml_pkg.sv @@
// ----------------------------------------------------------------------------
// fdml_pkg
// Widths, register indexes, mode codes, constants and helpers for the
// flight director mode law.
// ----------------------------------------------------------------------------
package fdml_pkg;

    localparam int BANK_W     = 17;
    localparam int HDG_W      = 17;
    localparam int ALT_W      = 24;
    localparam int VS_W       = 16;
    localparam int LOC_W      = 14;
    localparam int GS_W       = 20;
    localparam int DEM_W      = 17;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int OP_W       = 26;
    localparam int PROD_W     = 2 * OP_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_HEADING = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_ALT     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_CLIMB   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_GAIN   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_GAIN  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_LIMIT  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_LIMIT = 4'd7;

    // mode codes
    localparam logic [2:0] MODE_HEADING  = 3'd0;
    localparam logic [2:0] MODE_ALTITUDE = 3'd1;
    localparam logic [2:0] MODE_APPROACH = 3'd2;
    localparam logic [2:0] MODE_CLIMB    = 3'd3;
    localparam logic [2:0] MODE_DESCENT  = 3'd4;
    localparam logic [2:0] MODE_GPS      = 3'd5;

    // reset values
    localparam logic [15:0] ROLL_GAIN_RST   = 16'd128;
    localparam logic [15:0] PITCH_GAIN_RST  = 16'd77;
    localparam logic [15:0] ROLL_LIMIT_RST  = 16'd7680;
    localparam logic [15:0] PITCH_LIMIT_RST = 16'd3840;

    localparam logic signed [17:0] FULL_TURN = 18'sd92160;
    localparam logic signed [17:0] HALF_TURN = 18'sd46080;

    // thresholds, all 1/256 units
    localparam logic [16:0] BANK_SCALE_THR = 17'd1280;
    localparam logic [23:0] ALT_NEAR_THR   = 24'd12800;
    localparam logic signed [24:0] ALT_FAR_THR = 25'sd25600;
    localparam logic [17:0] CLIMB_PITCH    = 18'd2048;
    localparam logic [13:0] LOC_WIDE_THR   = 14'd256;
    localparam logic [13:0] LOC_CAPT_THR   = 14'd51;
    localparam logic [13:0] LOC_LOSS_THR   = 14'd103;
    localparam logic [19:0] GS_WIDE_THR    = 20'd38400;
    localparam logic [19:0] GS_CAPT_THR    = 20'd12800;
    localparam logic [19:0] GS_LOSS_THR    = 20'd25600;
    localparam logic [16:0] LOC_CAPT_LIM   = 17'd2560;
    localparam logic [16:0] LOC_WIDE_LIM   = 17'd5120;
    localparam logic [11:0] GS_CAPT_LIM    = 12'd1280;
    localparam logic [11:0] GS_WIDE_LIM    = 12'd2560;

    // reciprocals: floor(y/5) = (y*RECIP5)>>28 for y < 2**26,
    // floor(y/25) = (y*RECIP25)>>24 for y < 2**20
    localparam logic [OP_W-1:0] RECIP5    = 26'd53687092;
    localparam int              RECIP5_SH = 28;
    localparam logic [OP_W-1:0] RECIP25    = 26'd671089;
    localparam int              RECIP25_SH = 24;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_MUL  = 5'b00100,
        S_POST = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        J_HEAD  = 2'd0,   // heading error times roll gain
        J_HDIV  = 2'd1,   // divide by 5 for banked scaling
        J_PITCH = 2'd2,   // altitude error times pitch gain
        J_PDIV  = 2'd3    // divide by 25 for climb, descent, glide slope
    } t_job;

    function automatic logic [15:0] clamp_mag(input logic [31:0] mag, input logic [15:0] lim);
        clamp_mag = (mag > {16'd0, lim}) ? lim : mag[15:0];
    endfunction

    function automatic logic signed [17:0] apply_sign(input logic [15:0] mag, input logic neg);
        logic signed [17:0] v;
        v = $signed({2'b00, mag});
        apply_sign = neg ? -v : v;
    endfunction

endpackage

@@ hdl/flight_director_mode_law.sv @@
// ----------------------------------------------------------------------------
// flight_director_mode_law
// Roll and pitch command laws for heading, altitude, climb, descent,
// GPS track and ILS approach, with localizer and glide-slope capture.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s         in         i_s_tvalid/o_s_tready  i_s_tdata  one sensor sample
//  m         out        o_m_tvalid/i_m_tready  o_m_tdata  roll, pitch, flags
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  Per sample: load, one multiply/post pair on the shared 26x26 multiplier
//  for heading gain outside approach, divide by 5 when banked and the pitch
//  term when the mode needs one, then finish; unused modes go from load to
//  finish. No sample is taken until finish. Reset is synchronous, active
//  low, and restores the register defaults and clears both capture flags. A
//  stalled result holds in the output register; finish waits for it.
// ----------------------------------------------------------------------------
module flight_director_mode_law (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // bank_angle, heading_now, altitude_now, climb_rate_now,
    // lateral_deviation, vertical_deviation, zero fill
    input  logic [fdml_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // roll_demand, pitch_demand, lateral_locked, vertical_locked, zero fill
    output logic [fdml_pkg::M_TDATA_W-1:0]     o_m_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fdml_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fdml_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // configuration
    logic [2:0]         r_mode;
    logic [16:0]        r_tgt_hdg;
    logic signed [23:0] r_tgt_alt;
    logic signed [15:0] r_tgt_vs;
    logic [15:0]        r_roll_gain;
    logic [15:0]        r_pitch_gain;
    logic [15:0]        r_roll_limit;
    logic [15:0]        r_pitch_limit;

    // sample
    logic signed [16:0] r_bank;
    logic [16:0]        r_hdg;
    logic signed [23:0] r_alt;
    logic signed [15:0] r_vs;
    logic signed [13:0] r_loc;
    logic signed [19:0] r_gs;

    // sequencer and datapath
    fdml_pkg::t_state            r_state;
    fdml_pkg::t_job              r_job;
    logic [fdml_pkg::OP_W-1:0]   r_op_a;
    logic [fdml_pkg::OP_W-1:0]   r_op_b;
    logic [fdml_pkg::PROD_W-1:0] r_prod;
    logic                        r_roll_neg;
    logic                        r_bank_big;
    logic signed [17:0]          r_roll;
    logic signed [17:0]          r_pitch;
    logic                        r_plan_run;
    fdml_pkg::t_job              r_plan_job;
    logic [fdml_pkg::OP_W-1:0]   r_plan_a;
    logic [fdml_pkg::OP_W-1:0]   r_plan_b;
    logic                        r_plan_neg;
    logic [11:0]                 r_plan_lim;
    logic                        r_a_small;
    logic signed [15:0]          r_vs_term;
    logic                        r_lat_cap;
    logic                        r_vert_cap;
    logic                        r_out_valid;
    logic [fdml_pkg::M_TDATA_W-1:0] r_out_data;

    // ---------------- sample decode for the load step ----------------
    logic signed [17:0] hdg_diff, hdg_err, hdg_err_abs, bank_abs;
    logic [15:0]        hdg_mag;
    logic [16:0]        bank_mag;
    logic signed [24:0] alt_err, alt_abs;
    logic [23:0]        alt_mag;
    logic [16:0]        climb_y;
    logic signed [16:0] vs_diff, vs_abs;
    logic [16:0]        vs_mag;
    logic [16:0]        vs_rnd;
    logic signed [15:0] vs_term;
    logic signed [14:0] loc_abs;
    logic [13:0]        loc_mag;
    logic [16:0]        loc_x5, loc_x10;
    logic [16:0]        ap_roll_mag;
    logic signed [20:0] gs_abs;
    logic [19:0]        gs_mag;
    logic [20:0]        gs_sum;

    logic                        pl_run;
    fdml_pkg::t_job              pl_job;
    logic [fdml_pkg::OP_W-1:0]   pl_a;
    logic [fdml_pkg::OP_W-1:0]   pl_b;
    logic                        pl_neg;
    logic [11:0]                 pl_lim;
    logic signed [17:0]          pl_preset;

    always_comb begin
        hdg_diff = $signed({1'b0, r_tgt_hdg}) - $signed({1'b0, r_hdg});
        if (hdg_diff > fdml_pkg::HALF_TURN) begin
            hdg_err = hdg_diff - fdml_pkg::FULL_TURN;
        end else if (hdg_diff < -fdml_pkg::HALF_TURN) begin
            hdg_err = hdg_diff + fdml_pkg::FULL_TURN;
        end else begin
            hdg_err = hdg_diff;
        end
        hdg_err_abs = (hdg_err < 0) ? -hdg_err : hdg_err;
        hdg_mag     = hdg_err_abs[15:0];

        bank_abs = (r_bank < 0) ? -18'(r_bank) : 18'(r_bank);
        bank_mag = bank_abs[16:0];

        alt_err = 25'(r_tgt_alt) - 25'(r_alt);
        alt_abs = (alt_err < 0) ? -alt_err : alt_err;
        alt_mag = alt_abs[23:0];
        // rdiv(8a, 100) == floor((2|a| + 12) / 25) for the near band
        climb_y = 17'({alt_mag[15:0], 1'b0}) + 17'd12;

        vs_diff = 17'(r_tgt_vs) - 17'(r_vs);
        vs_abs  = (vs_diff < 0) ? -vs_diff : vs_diff;
        vs_mag  = vs_abs[16:0];
        vs_rnd  = (vs_mag + 17'd2) >> 2;
        vs_term = (vs_diff < 0) ? -$signed({1'b0, vs_rnd[14:0]})
                                :  $signed({1'b0, vs_rnd[14:0]});

        loc_abs = (r_loc < 0) ? -15'(r_loc) : 15'(r_loc);
        loc_mag = loc_abs[13:0];
        loc_x5  = ({3'd0, loc_mag} << 2) + {3'd0, loc_mag};
        loc_x10 = {loc_x5[15:0], 1'b0};
        if (r_lat_cap) begin
            ap_roll_mag = (loc_x5 > fdml_pkg::LOC_CAPT_LIM) ? fdml_pkg::LOC_CAPT_LIM : loc_x5;
        end else if (loc_mag > fdml_pkg::LOC_WIDE_THR) begin
            ap_roll_mag = (loc_x10 > fdml_pkg::LOC_WIDE_LIM) ? fdml_pkg::LOC_WIDE_LIM : loc_x10;
        end else begin
            ap_roll_mag = '0;
        end

        gs_abs = (r_gs < 0) ? -21'(r_gs) : 21'(r_gs);
        gs_mag = gs_abs[19:0];
        gs_sum = {1'b0, gs_mag} + 21'd100;   // >>3 then /25 gives /200

        // pitch plan by mode
        pl_run    = 1'b0;
        pl_job    = fdml_pkg::J_PDIV;
        pl_a      = '0;
        pl_b      = fdml_pkg::RECIP25;
        pl_neg    = 1'b0;
        pl_lim    = fdml_pkg::GS_WIDE_LIM;
        pl_preset = '0;
        case (r_mode)
            fdml_pkg::MODE_ALTITUDE: begin
                pl_run = 1'b1;
                pl_job = fdml_pkg::J_PITCH;
                pl_a   = fdml_pkg::OP_W'(alt_mag);
                pl_b   = fdml_pkg::OP_W'(r_pitch_gain);
                pl_neg = alt_err < 0;
            end
            fdml_pkg::MODE_CLIMB: begin
                if (alt_err > fdml_pkg::ALT_FAR_THR) begin
                    pl_preset = $signed(fdml_pkg::CLIMB_PITCH);
                end else if (alt_err > 0) begin
                    pl_run = 1'b1;
                    pl_a   = fdml_pkg::OP_W'(climb_y);
                end
            end
            fdml_pkg::MODE_DESCENT: begin
                if (alt_err < -fdml_pkg::ALT_FAR_THR) begin
                    pl_preset = -$signed(fdml_pkg::CLIMB_PITCH);
                end else if (alt_err < 0) begin
                    pl_run = 1'b1;
                    pl_a   = fdml_pkg::OP_W'(climb_y);
                    pl_neg = 1'b1;
                end
            end
            fdml_pkg::MODE_APPROACH: begin
                if (r_vert_cap || gs_mag > fdml_pkg::GS_WIDE_THR) begin
                    pl_run = 1'b1;
                    pl_a   = fdml_pkg::OP_W'(gs_sum[20:3]);
                    pl_neg = r_gs < 0;
                    pl_lim = r_vert_cap ? fdml_pkg::GS_CAPT_LIM : fdml_pkg::GS_WIDE_LIM;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------- post-multiply views of the product ----------------
    logic [39:0] rnd8_sum;
    logic [31:0] rnd8;
    logic [31:0] y5_sum;
    logic [fdml_pkg::OP_W-1:0] y5;
    logic [23:0] q5;
    logic [15:0] q25;

    always_comb begin
        rnd8_sum = r_prod[39:0] + 40'd128;
        rnd8     = rnd8_sum[39:8];
        // rdiv(e*g*4, 1280) == floor((e*g + 160) / 320)
        y5_sum   = r_prod[31:0] + 32'd160;
        y5       = y5_sum[31:6];
        q5       = r_prod[fdml_pkg::RECIP5_SH +: 24];
        q25      = r_prod[fdml_pkg::RECIP25_SH +: 16];
    end

    logic signed [17:0] pitch_abs;
    logic [15:0]        pitch_fin;
    logic signed [17:0] pitch_out;
    logic [15:0]        roll_post_mag;

    always_comb begin
        pitch_abs     = (r_pitch < 0) ? -r_pitch : r_pitch;
        pitch_fin     = fdml_pkg::clamp_mag({15'd0, pitch_abs[16:0]}, r_pitch_limit);
        pitch_out     = fdml_pkg::apply_sign(pitch_fin, r_pitch < 0);
        roll_post_mag = (r_job == fdml_pkg::J_HDIV)
                      ? fdml_pkg::clamp_mag({8'd0, q5}, r_roll_limit)
                      : fdml_pkg::clamp_mag(rnd8, r_roll_limit);
    end

    assign o_s_tready  = (r_state == fdml_pkg::S_IDLE);
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= fdml_pkg::MODE_HEADING;
            r_tgt_hdg     <= '0;
            r_tgt_alt     <= '0;
            r_tgt_vs      <= '0;
            r_roll_gain   <= fdml_pkg::ROLL_GAIN_RST;
            r_pitch_gain  <= fdml_pkg::PITCH_GAIN_RST;
            r_roll_limit  <= fdml_pkg::ROLL_LIMIT_RST;
            r_pitch_limit <= fdml_pkg::PITCH_LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fdml_pkg::REG_MODE:        r_mode        <= i_cfg_data[2:0];
                fdml_pkg::REG_TGT_HEADING: r_tgt_hdg     <= i_cfg_data[16:0];
                fdml_pkg::REG_TGT_ALT:     r_tgt_alt     <= $signed(i_cfg_data[23:0]);
                fdml_pkg::REG_TGT_CLIMB:   r_tgt_vs      <= $signed(i_cfg_data[15:0]);
                fdml_pkg::REG_ROLL_GAIN:   r_roll_gain   <= i_cfg_data[15:0];
                fdml_pkg::REG_PITCH_GAIN:  r_pitch_gain  <= i_cfg_data[15:0];
                fdml_pkg::REG_ROLL_LIMIT:  r_roll_limit  <= i_cfg_data[15:0];
                fdml_pkg::REG_PITCH_LIMIT: r_pitch_limit <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fdml_pkg::S_IDLE;
            r_lat_cap   <= 1'b0;
            r_vert_cap  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                fdml_pkg::S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_bank  <= $signed(i_s_tdata[16:0]);
                        r_hdg   <= i_s_tdata[33:17];
                        r_alt   <= $signed(i_s_tdata[57:34]);
                        r_vs    <= $signed(i_s_tdata[73:58]);
                        r_loc   <= $signed(i_s_tdata[87:74]);
                        r_gs    <= $signed(i_s_tdata[107:88]);
                        r_state <= fdml_pkg::S_LOAD;
                    end
                end
                fdml_pkg::S_LOAD: begin
                    r_roll     <= '0;
                    r_pitch    <= pl_preset;
                    r_plan_run <= pl_run;
                    r_plan_job <= pl_job;
                    r_plan_a   <= pl_a;
                    r_plan_b   <= pl_b;
                    r_plan_neg <= pl_neg;
                    r_plan_lim <= pl_lim;
                    r_a_small  <= alt_mag < fdml_pkg::ALT_NEAR_THR;
                    r_vs_term  <= vs_term;
                    r_roll_neg <= hdg_err < 0;
                    r_bank_big <= bank_mag > fdml_pkg::BANK_SCALE_THR;
                    case (r_mode)
                        fdml_pkg::MODE_HEADING, fdml_pkg::MODE_GPS,
                        fdml_pkg::MODE_ALTITUDE, fdml_pkg::MODE_CLIMB,
                        fdml_pkg::MODE_DESCENT: begin
                            r_op_a  <= fdml_pkg::OP_W'(hdg_mag);
                            r_op_b  <= fdml_pkg::OP_W'(r_roll_gain);
                            r_job   <= fdml_pkg::J_HEAD;
                            r_state <= fdml_pkg::S_MUL;
                        end
                        fdml_pkg::MODE_APPROACH: begin
                            r_roll <= fdml_pkg::apply_sign(
                                fdml_pkg::clamp_mag({15'd0, ap_roll_mag}, r_roll_limit),
                                r_loc < 0);
                            // demands above use the flags as they were
                            if (r_lat_cap) begin
                                r_lat_cap <= !(loc_mag >= fdml_pkg::LOC_LOSS_THR);
                            end else begin
                                r_lat_cap <= loc_mag <= fdml_pkg::LOC_CAPT_THR;
                            end
                            if (r_vert_cap) begin
                                r_vert_cap <= !(gs_mag > fdml_pkg::GS_LOSS_THR);
                            end else begin
                                r_vert_cap <= gs_mag < fdml_pkg::GS_CAPT_THR;
                            end
                            r_op_a  <= pl_a;
                            r_op_b  <= pl_b;
                            r_job   <= fdml_pkg::J_PDIV;
                            r_state <= pl_run ? fdml_pkg::S_MUL : fdml_pkg::S_FIN;
                        end
                        default: begin
                            r_state <= fdml_pkg::S_FIN;
                        end
                    endcase
                end
                fdml_pkg::S_MUL: begin
                    r_prod  <= r_op_a * r_op_b;
                    r_state <= fdml_pkg::S_POST;
                end
                fdml_pkg::S_POST: begin
                    case (r_job)
                        fdml_pkg::J_HEAD, fdml_pkg::J_HDIV: begin
                            if (r_job == fdml_pkg::J_HEAD && r_bank_big) begin
                                r_op_a  <= y5;
                                r_op_b  <= fdml_pkg::RECIP5;
                                r_job   <= fdml_pkg::J_HDIV;
                                r_state <= fdml_pkg::S_MUL;
                            end else begin
                                r_roll <= fdml_pkg::apply_sign(roll_post_mag, r_roll_neg);
                                if (r_plan_run) begin
                                    r_op_a  <= r_plan_a;
                                    r_op_b  <= r_plan_b;
                                    r_job   <= r_plan_job;
                                    r_state <= fdml_pkg::S_MUL;
                                end else begin
                                    r_state <= fdml_pkg::S_FIN;
                                end
                            end
                        end
                        fdml_pkg::J_PITCH: begin
                            r_pitch <= fdml_pkg::apply_sign(
                                           fdml_pkg::clamp_mag(rnd8, r_pitch_limit), r_plan_neg)
                                     + (r_a_small ? 18'(r_vs_term) : 18'sd0);
                            r_state <= fdml_pkg::S_FIN;
                        end
                        default: begin
                            r_pitch <= fdml_pkg::apply_sign(
                                fdml_pkg::clamp_mag({16'd0, q25}, {4'd0, r_plan_lim}),
                                r_plan_neg);
                            r_state <= fdml_pkg::S_FIN;
                        end
                    endcase
                end
                fdml_pkg::S_FIN: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_data  <= {4'd0, r_vert_cap, r_lat_cap,
                                        pitch_out[16:0], r_roll[16:0]};
                        r_out_valid <= 1'b1;
                        r_state     <= fdml_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= fdml_pkg::S_IDLE;
                end
            endcase
        end
    end

    // ---------------- assertions ----------------
    a_roll_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[16:0]) <= $signed({2'b00, r_roll_limit}))
                    && ($signed(o_m_tdata[16:0]) >= -$signed({2'b00, r_roll_limit})))
        else $error("roll demand beyond roll limit");

    a_pitch_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[33:17]) <= $signed({2'b00, r_pitch_limit}))
                    && ($signed(o_m_tdata[33:17]) >= -$signed({2'b00, r_pitch_limit})))
        else $error("pitch demand beyond pitch limit");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == fdml_pkg::S_LOAD))
        else $error("accepted sample not loaded");

    a_capture_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdml_pkg::S_LOAD && r_mode != fdml_pkg::MODE_APPROACH)
        |=> ($stable(r_lat_cap) && $stable(r_vert_cap)))
        else $error("capture flags changed outside approach");

    a_fin_not_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fdml_pkg::S_FIN && r_out_valid && !i_m_tready)
        |=> (r_state == fdml_pkg::S_FIN && $stable(r_out_data)))
        else $error("pending result overwritten");

endmodule

@@ tb/sv/flight_director_mode_law_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flight_director_mode_law_tb
// Streams sensor samples into the mode law under random input bursts and
// output stalls. Every accepted sample is run through a bench-side model of
// the laws and capture hysteresis; each result is compared field by field.
// Directed checks (defaults, heading wrap, bank scaling, altitude, climb and
// descent thresholds, approach capture/loss, unused modes) come first, then
// randomized settings with random samples.
// ----------------------------------------------------------------------------
module flight_director_mode_law_tb;
    import fdml_pkg::*;

    localparam int     CYCLE_LIMIT   = 250000;
    localparam int     SETTLE_CYCLES = 12;
    localparam int     RANDOM_PHASES = 12;
    localparam int     PHASE_ITEMS   = 90;
    localparam longint TURN_360      = 92160;
    localparam longint TURN_180      = 46080;

    // mode codes with no law behind them
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    // first register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd8;

    typedef struct {
        logic signed [BANK_W-1:0] bank_angle;
        logic        [HDG_W-1:0]  heading_now;
        logic signed [ALT_W-1:0]  altitude_now;
        logic signed [VS_W-1:0]   climb_rate_now;
        logic signed [LOC_W-1:0]  lateral_deviation;
        logic signed [GS_W-1:0]   vertical_deviation;
    } sample_t;

    typedef struct {
        logic signed [DEM_W-1:0] roll_demand;
        logic signed [DEM_W-1:0] pitch_demand;
        logic                    lateral_locked;
        logic                    vertical_locked;
    } demand_t;

    typedef struct {
        logic        [2:0]       mode;
        logic        [HDG_W-1:0] tgt_heading;
        logic signed [ALT_W-1:0] tgt_alt;
        logic signed [VS_W-1:0]  tgt_climb;
        logic        [15:0]      roll_gain;
        logic        [15:0]      pitch_gain;
        logic        [15:0]      roll_limit;
        logic        [15:0]      pitch_limit;
    } settings_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    settings_t law_cfg;
    logic      loc_captured;
    logic      gs_captured;
    demand_t   pending_demands[$];
    demand_t   seen_demand;
    demand_t   due_demand;
    int        error_count = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;
    bit        valid_held  = 1'b0;
    int        stall_tick  = 0;
    int        stall_style = 0;
    longint    loc_walk    = 0;
    longint    gs_walk     = 0;

    flight_director_mode_law dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // bench-side law model
    // ------------------------------------------------------------------
    function automatic settings_t reset_settings();
        settings_t c;
        c.mode        = MODE_HEADING;
        c.tgt_heading = '0;
        c.tgt_alt     = '0;
        c.tgt_climb   = '0;
        c.roll_gain   = ROLL_GAIN_RST;
        c.pitch_gain  = PITCH_GAIN_RST;
        c.roll_limit  = ROLL_LIMIT_RST;
        c.pitch_limit = PITCH_LIMIT_RST;
        return c;
    endfunction

    function automatic longint mag64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // nearest, ties away from zero
    function automatic longint round_div(input longint n, input longint d);
        longint q;
        q = (mag64(n) + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clip(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint steer_roll(input longint bank, input longint hdg);
        longint err;
        longint gain;
        err  = law_cfg.tgt_heading;
        err  = err - hdg;
        gain = law_cfg.roll_gain;
        // exactly +-180 stays as is
        repeat (3) begin
            if (err > TURN_180)
                err -= TURN_360;
            else if (err < -TURN_180)
                err += TURN_360;
        end
        // banked beyond 5 deg: gain scaled by 4/5
        if (mag64(bank) > 1280)
            return round_div(err * gain * 4, 1280);
        return round_div(err * gain, 256);
    endfunction

    function automatic demand_t predict_demand(input sample_t s);
        longint  bank, hdg, alt, vs, loc, gs;
        longint  tgt_alt, tgt_vs, pgain, rlim, plim;
        longint  alt_err, roll, pitch;
        demand_t d;
        bank    = s.bank_angle;
        hdg     = s.heading_now;
        alt     = s.altitude_now;
        vs      = s.climb_rate_now;
        loc     = s.lateral_deviation;
        gs      = s.vertical_deviation;
        tgt_alt = law_cfg.tgt_alt;
        tgt_vs  = law_cfg.tgt_climb;
        pgain   = law_cfg.pitch_gain;
        rlim    = law_cfg.roll_limit;
        plim    = law_cfg.pitch_limit;
        alt_err = tgt_alt - alt;
        roll    = 0;
        pitch   = 0;
        case (law_cfg.mode)
            MODE_HEADING, MODE_GPS: begin
                roll = steer_roll(bank, hdg);
            end
            MODE_ALTITUDE: begin
                pitch = clip(round_div(alt_err * pgain, 256), plim);
                if (mag64(alt_err) < 12800)
                    pitch += round_div(tgt_vs - vs, 4);
                roll = steer_roll(bank, hdg);
            end
            MODE_APPROACH: begin
                if (loc_captured)
                    roll = clip(loc * 5, 2560);
                else if (mag64(loc) > 256)
                    roll = clip(loc * 10, 5120);
                if (gs_captured)
                    pitch = clip(round_div(gs, 200), 1280);
                else if (mag64(gs) > 38400)
                    pitch = clip(round_div(gs, 200), 2560);
                // hysteresis, applied after the demands of this sample
                if (!loc_captured && mag64(loc) <= 51)
                    loc_captured = 1'b1;
                if (loc_captured && mag64(loc) >= 103)
                    loc_captured = 1'b0;
                if (!gs_captured && mag64(gs) < 12800)
                    gs_captured = 1'b1;
                if (gs_captured && mag64(gs) > 25600)
                    gs_captured = 1'b0;
            end
            MODE_CLIMB: begin
                if (alt_err > 25600)
                    pitch = 2048;
                else if (alt_err > 0)
                    pitch = round_div(alt_err * 8, 100);
                roll = steer_roll(bank, hdg);
            end
            MODE_DESCENT: begin
                if (alt_err < -25600)
                    pitch = -2048;
                else if (alt_err < 0)
                    pitch = round_div(alt_err * 8, 100);
                roll = steer_roll(bank, hdg);
            end
            default: ;
        endcase
        roll              = clip(roll, rlim);
        pitch             = clip(pitch, plim);
        d.roll_demand     = roll[DEM_W-1:0];
        d.pitch_demand    = pitch[DEM_W-1:0];
        d.lateral_locked  = loc_captured;
        d.vertical_locked = gs_captured;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // result checker and output stall pattern
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_demand.roll_demand     = o_m_tdata[DEM_W-1:0];
            seen_demand.pitch_demand    = o_m_tdata[2*DEM_W-1:DEM_W];
            seen_demand.lateral_locked  = o_m_tdata[2*DEM_W];
            seen_demand.vertical_locked = o_m_tdata[2*DEM_W+1];
            if (pending_demands.size() == 0) begin
                $error("result with no sample pending: roll %0d pitch %0d",
                       seen_demand.roll_demand, seen_demand.pitch_demand);
                error_count++;
            end else begin
                due_demand = pending_demands.pop_front();
                if (seen_demand.roll_demand !== due_demand.roll_demand) begin
                    $error("roll_demand: expected %0d, got %0d",
                           due_demand.roll_demand, seen_demand.roll_demand);
                    error_count++;
                end
                if (seen_demand.pitch_demand !== due_demand.pitch_demand) begin
                    $error("pitch_demand: expected %0d, got %0d",
                           due_demand.pitch_demand, seen_demand.pitch_demand);
                    error_count++;
                end
                if (seen_demand.lateral_locked !== due_demand.lateral_locked) begin
                    $error("lateral_locked: expected %0b, got %0b",
                           due_demand.lateral_locked, seen_demand.lateral_locked);
                    error_count++;
                end
                if (seen_demand.vertical_locked !== due_demand.vertical_locked) begin
                    $error("vertical_locked: expected %0b, got %0b",
                           due_demand.vertical_locked, seen_demand.vertical_locked);
                    error_count++;
                end
            end
        end
        stall_tick++;
        if (stall_tick % 96 == 0)
            stall_style = $urandom_range(0, 3);
        case (stall_style)
            0:       i_m_tready <= 1'b1;
            1:       i_m_tready <= (stall_tick % 4) != 3;
            2:       i_m_tready <= $urandom_range(0, 2) != 0;
            default: i_m_tready <= stall_tick[4];
        endcase
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic drop_valid();
        if (valid_held)
            i_s_tvalid <= 1'b0;
        valid_held = 1'b0;
    endtask

    task automatic send_sample(input sample_t s);
        if (burst_left == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
        end
        burst_left--;
        valid_held = 1'b1;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, s.vertical_deviation, s.lateral_deviation, s.climb_rate_now,
                       s.altitude_now, s.heading_now, s.bank_angle};
        do @(posedge i_clk); while (!o_s_tready);
        pending_demands.push_back(predict_demand(s));
    endtask

    // wait until every request has its result, then let the block settle
    task automatic drain();
        drop_valid();
        burst_left = 0;
        while (pending_demands.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:        law_cfg.mode        = value[2:0];
            REG_TGT_HEADING: law_cfg.tgt_heading = value[HDG_W-1:0];
            REG_TGT_ALT:     law_cfg.tgt_alt     = value[ALT_W-1:0];
            REG_TGT_CLIMB:   law_cfg.tgt_climb   = value[VS_W-1:0];
            REG_ROLL_GAIN:   law_cfg.roll_gain   = value[15:0];
            REG_PITCH_GAIN:  law_cfg.pitch_gain  = value[15:0];
            REG_ROLL_LIMIT:  law_cfg.roll_limit  = value[15:0];
            REG_PITCH_LIMIT: law_cfg.pitch_limit = value[15:0];
            default: ;
        endcase
    endtask

    // noisy: junk in the unused upper data bits plus a write to an unmapped index
    task automatic load_settings(input settings_t c, input bit noisy);
        logic [CFG_DATA_W-1:0] junk;
        junk = noisy ? CFG_DATA_W'($urandom) : '0;
        write_reg(REG_MODE,        {junk[CFG_DATA_W-1:3], c.mode});
        write_reg(REG_TGT_HEADING, {junk[CFG_DATA_W-1:HDG_W], c.tgt_heading});
        write_reg(REG_TGT_ALT,     c.tgt_alt);
        write_reg(REG_TGT_CLIMB,   {junk[CFG_DATA_W-1:VS_W], c.tgt_climb});
        write_reg(REG_ROLL_GAIN,   {junk[CFG_DATA_W-1:16], c.roll_gain});
        write_reg(REG_PITCH_GAIN,  {junk[CFG_DATA_W-1:16], c.pitch_gain});
        write_reg(REG_ROLL_LIMIT,  {junk[CFG_DATA_W-1:16], c.roll_limit});
        write_reg(REG_PITCH_LIMIT, {junk[CFG_DATA_W-1:16], c.pitch_limit});
        if (noisy)
            write_reg(REG_UNMAPPED + 4'($urandom_range(0, 7)), junk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic longint sint(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic sample_t make_sample(input longint bank, input longint hdg,
                                            input longint alt, input longint vs,
                                            input longint loc, input longint gs);
        sample_t s;
        s.bank_angle         = bank[BANK_W-1:0];
        s.heading_now        = hdg[HDG_W-1:0];
        s.altitude_now       = alt[ALT_W-1:0];
        s.climb_rate_now     = vs[VS_W-1:0];
        s.lateral_deviation  = loc[LOC_W-1:0];
        s.vertical_deviation = gs[GS_W-1:0];
        return s;
    endfunction

    function automatic settings_t random_settings(input int phase);
        settings_t c;
        case (phase % 12)
            0, 7:    c.mode = MODE_ALTITUDE;
            1:       c.mode = MODE_HEADING;
            2, 9:    c.mode = MODE_CLIMB;
            4, 10:   c.mode = MODE_DESCENT;
            5:       c.mode = MODE_GPS;
            8:       c.mode = MODE_SPARE_LO;
            default: c.mode = MODE_APPROACH;
        endcase
        c.tgt_heading = ($urandom_range(0, 7) == 0) ? 17'($urandom)
                                                    : 17'($urandom_range(0, 92159));
        c.tgt_alt     = 24'($urandom);
        c.tgt_climb   = 16'(sint(-25600, 25600));
        c.roll_gain   = 16'($urandom_range(0, 1024));
        c.pitch_gain  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 1024));
        c.roll_limit  = 16'($urandom_range(0, 46080));
        c.pitch_limit = 16'($urandom_range(0, 46080));
        if (phase == 0) begin
            c.roll_limit  = '0;
            c.pitch_limit = '0;
        end else if (phase == 1) begin
            c.roll_gain   = '1;
            c.pitch_gain  = '1;
            c.roll_limit  = '1;
            c.pitch_limit = '1;
        end else if (phase == 2) begin
            c.roll_gain   = '0;
            c.pitch_gain  = '0;
            c.roll_limit  = 16'd46080;
            c.pitch_limit = 16'd46080;
        end
        return c;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        longint  hdg;
        longint  alt;
        // deviations follow damped random walks so capture and loss both happen
        if ($urandom_range(0, 11) == 0)
            loc_walk = ($urandom_range(0, 3) == 0) ? sint(-5120, 5120) : sint(-600, 600);
        else
            loc_walk += sint(-40, 40) - loc_walk / 8;
        if ($urandom_range(0, 11) == 0)
            gs_walk = ($urandom_range(0, 3) == 0) ? sint(-524288, 524287)
                                                  : sint(-60000, 60000);
        else
            gs_walk += sint(-4000, 4000) - gs_walk / 8;
        if ($urandom_range(0, 7) == 0) begin
            // raw bits over the full field widths
            s.bank_angle         = 17'($urandom);
            s.heading_now        = 17'($urandom);
            s.altitude_now       = 24'($urandom);
            s.climb_rate_now     = 16'($urandom);
            s.lateral_deviation  = 14'($urandom);
            s.vertical_deviation = 20'($urandom);
            return s;
        end
        case ($urandom_range(0, 2))
            0: hdg = sint(0, 92159);
            1: begin
                hdg = law_cfg.tgt_heading;
                hdg += sint(-512, 512);
            end
            default: begin
                // near the +-180 deg wrap point
                hdg = law_cfg.tgt_heading;
                hdg += TURN_180 + sint(-64, 64);
            end
        endcase
        hdg = hdg % TURN_360;
        if (hdg < 0)
            hdg += TURN_360;
        alt = law_cfg.tgt_alt;
        case ($urandom_range(0, 3))
            0:       alt -= sint(-200, 200);
            1, 2:    alt -= sint(-30000, 30000);
            default: alt = sint(-8388608, 8388607);
        endcase
        s = make_sample(($urandom_range(0, 1) == 0) ? sint(-1290, 1290) : sint(-46080, 46080),
                        hdg, alt, sint(-25600, 25600), loc_walk, gs_walk);
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_heading_law();
        settings_t c;
        // reset defaults first, no register written yet
        drain();
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(1280, 46080, 0, 0, 0, 0));       // error exactly -180
        send_sample(make_sample(1281, 46079, 0, 0, 0, 0));       // just banked
        send_sample(make_sample(-1281, 92159, 0, 0, 0, 0));      // wraps to +1
        send_sample(make_sample(-65536, 131071, 0, 0, 0, 0));    // beyond a full turn
        drain();
        c             = law_cfg;
        c.mode        = MODE_GPS;
        c.tgt_heading = 17'd92159;
        c.roll_gain   = '1;
        c.roll_limit  = '1;
        load_settings(c, 1'b0);
        send_sample(make_sample(46080, 0, 0, 0, 0, 0));          // wraps to -1
        send_sample(make_sample(-46080, 46079, 0, 0, 0, 0));     // error exactly +180
    endtask

    task automatic test_altitude_law();
        settings_t c;
        drain();
        c             = reset_settings();
        c.mode        = MODE_ALTITUDE;
        c.tgt_climb   = 16'sd25600;
        c.pitch_limit = 16'd46080;
        load_settings(c, 1'b0);
        send_sample(make_sample(0, 100, -12799, -25600, 0, 0));  // near: rate term added
        send_sample(make_sample(0, 100, -12800, 25600, 0, 0));   // just outside near band
        send_sample(make_sample(2000, 0, 8388607, 25600, 0, 0));
        send_sample(make_sample(0, 0, -8388608, -25600, 0, 0));
    endtask

    task automatic test_climb_descent();
        settings_t c;
        drain();
        c      = reset_settings();
        c.mode = MODE_CLIMB;
        load_settings(c, 1'b0);
        send_sample(make_sample(0, 0, -25601, 0, 0, 0));
        send_sample(make_sample(0, 0, -25600, 0, 0, 0));
        send_sample(make_sample(0, 0, -7, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        drain();
        c.mode = MODE_DESCENT;
        load_settings(c, 1'b0);
        send_sample(make_sample(0, 0, 25601, 0, 0, 0));
        send_sample(make_sample(0, 0, 25600, 0, 0, 0));
        send_sample(make_sample(0, 0, 7, 0, 0, 0));
    endtask

    task automatic test_approach_capture();
        settings_t c;
        drain();
        c      = reset_settings();
        c.mode = MODE_APPROACH;
        load_settings(c, 1'b0);
        send_sample(make_sample(0, 0, 0, 0, 300, 38401));       // wide demands
        send_sample(make_sample(0, 0, 0, 0, 51, 12799));         // both capture
        send_sample(make_sample(0, 0, 0, 0, -102, -25600));      // both hold
        send_sample(make_sample(0, 0, 0, 0, 103, 25601));        // both lost
        send_sample(make_sample(0, 0, 0, 0, 52, -38400));        // inside dead bands
        send_sample(make_sample(0, 0, 0, 0, -8192, -524288));
        send_sample(make_sample(0, 0, 0, 0, 8191, 524287));
    endtask

    task automatic test_unused_modes();
        settings_t c;
        drain();
        c      = law_cfg;
        c.mode = MODE_SPARE_LO;
        load_settings(c, 1'b1);
        send_sample(make_sample(3000, 5000, 1000, 100, 20, 100));
        drain();
        c.mode = MODE_SPARE_HI;
        load_settings(c, 1'b1);
        send_sample(make_sample(-3000, 80000, -1000, -100, -300, -50000));
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            load_settings(random_settings(p), (p % 3) == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_sample(random_sample());
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_m_tready  <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        law_cfg      = reset_settings();
        loc_captured = 1'b0;
        gs_captured  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_heading_law();
        test_altitude_law();
        test_climb_descent();
        test_approach_capture();
        test_unused_modes();
        test_random_phases();
        drain();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
